FILE: rtl/aprd_pkg.sv
// Shared constants, types and state encodings for the audio peak/RMS decimator.
package aprd_pkg;

   localparam int DEF_MAX_CHANNELS = 8;
   localparam int DEF_SAMPLE_BITS  = 16;
   localparam int DEF_COUNT_BITS   = 24;

   localparam int FPB_W           = 24;
   localparam int CHANNEL_COUNT_W = 4;
   localparam int CSR_DATA_W      = 24;

   localparam logic [FPB_W-1:0]           FPB_RESET           = 24'd1;
   localparam logic [CHANNEL_COUNT_W-1:0] CHANNEL_COUNT_RESET = 4'd2;

   localparam int CHAN_W       = 3;
   localparam int PEAK_W       = 11;
   localparam int RMS_W        = 10;
   localparam int RSP_FIELDS_W = CHAN_W + 2 * PEAK_W + RMS_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int PEAK_SCALE = 1000;

   localparam int                      SCALE_SQ_W = 20;
   localparam logic [SCALE_SQ_W-1:0]   SCALE_SQ   = 20'd1000000;
   localparam logic [RMS_W-1:0]        RMS_MAX    = 10'd1000;

   typedef enum logic {
      CSR_FRAMES_PER_BLOCK = 1'b0,
      CSR_CHANNEL_COUNT    = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_EMIT_START,
      ST_EMIT_WAIT,
      ST_EMIT_PUT
   } aprd_state_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_MUL,
      PH_DIV,
      PH_CLAMP,
      PH_ROOT,
      PH_DONE
   } rms_phase_type;

   typedef struct packed {
      logic load;
      logic update;
      logic clear;
   } stats_ctrl_type;

endpackage

FILE: rtl/aprd_stats.sv
// Per-channel max/min/sum-of-squares store with sample square and update stage.
module aprd_stats #(
   parameter int MAX_CHANNELS = aprd_pkg::DEF_MAX_CHANNELS,
   parameter int SAMPLE_BITS  = aprd_pkg::DEF_SAMPLE_BITS,
   parameter int COUNT_BITS   = aprd_pkg::DEF_COUNT_BITS,
   localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
   localparam int SUM_W = 2 * SAMPLE_BITS + COUNT_BITS - 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  aprd_pkg::stats_ctrl_type      ctrl,
   input  logic [CH_W-1:0]               sel,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output logic signed [SAMPLE_BITS-1:0] rd_max,
   output logic signed [SAMPLE_BITS-1:0] rd_min,
   output logic [SUM_W-1:0]              rd_sumsq
);
   import aprd_pkg::*;

   localparam int SQ_W = 2 * SAMPLE_BITS - 1;
   localparam logic signed [SAMPLE_BITS-1:0] MAX_RESET = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] MIN_RESET = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   logic signed [SAMPLE_BITS-1:0]   sample_ff;
   logic [SQ_W-1:0]                 sq_ff;
   logic signed [2*SAMPLE_BITS-1:0] sq_full;
   logic [SQ_W-1:0]                 sq_in;

   logic signed [SAMPLE_BITS-1:0] max_ff [MAX_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] min_ff [MAX_CHANNELS];
   logic [SUM_W-1:0]              sum_ff [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0]       valid_ff;
   logic [MAX_CHANNELS-1:0]       valid_in;

   logic signed [SAMPLE_BITS-1:0] max_in;
   logic signed [SAMPLE_BITS-1:0] min_in;
   logic [SUM_W-1:0]              sum_in;

   assign sq_full = sample * sample;
   assign sq_in   = sq_full[SQ_W-1:0];

   assign rd_max   = valid_ff[sel] ? max_ff[sel] : MAX_RESET;
   assign rd_min   = valid_ff[sel] ? min_ff[sel] : MIN_RESET;
   assign rd_sumsq = valid_ff[sel] ? sum_ff[sel] : '0;

   assign max_in = (sample_ff > rd_max) ? sample_ff : rd_max;
   assign min_in = (sample_ff < rd_min) ? sample_ff : rd_min;
   assign sum_in = rd_sumsq + SUM_W'(sq_ff);

   always_comb begin
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = '0;
      end else if (ctrl.update) begin
         valid_in[sel] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         sample_ff <= sample;
         sq_ff     <= sq_in;
      end
      if (ctrl.update) begin
         max_ff[sel] <= max_in;
         min_ff[sel] <= min_in;
         sum_ff[sel] <= sum_in;
      end
   end

endmodule

FILE: rtl/aprd_rms.sv
// Bit-serial RMS unit: shift-add by 10^6, restoring divide by frame count, restoring sqrt.
module aprd_rms #(
   parameter int SAMPLE_BITS = aprd_pkg::DEF_SAMPLE_BITS,
   parameter int COUNT_BITS  = aprd_pkg::DEF_COUNT_BITS,
   localparam int SUM_W = 2 * SAMPLE_BITS + COUNT_BITS - 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [SUM_W-1:0]           sumsq,
   input  logic [COUNT_BITS-1:0]      frames,
   output logic                       done,
   output logic [aprd_pkg::RMS_W-1:0] rms
);
   import aprd_pkg::*;

   localparam int PROD_W = SUM_W + SCALE_SQ_W;
   localparam int SHIFT  = 2 * (SAMPLE_BITS - 1);
   localparam int DIV_W  = PROD_W - SHIFT;
   localparam int STEP_W = $clog2(DIV_W);
   localparam int Y_W    = 2 * RMS_W;

   rms_phase_type phase_ff, phase_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [SCALE_SQ_W-1:0] coef_ff, coef_in;
   logic [PROD_W-1:0]     acc_ff, acc_in;
   logic [COUNT_BITS-1:0] den_ff, den_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]      quo_ff, quo_in;
   logic [Y_W-1:0]        y_ff, y_in;
   logic [RMS_W-1:0]      root_ff, root_in;
   logic [RMS_W:0]        rrem_ff, rrem_in;

   logic [COUNT_BITS:0] div_trial;
   logic [COUNT_BITS:0] div_diff;
   logic                div_ge;
   logic [RMS_W+2:0]    rt_trial;
   logic [RMS_W+2:0]    rt_test;
   logic [RMS_W+2:0]    rt_diff;
   logic                rt_ge;
   logic                step_last;
   logic                over;

   assign div_trial = {rem_ff, acc_ff[PROD_W-1]};
   assign div_diff  = div_trial - {1'b0, den_ff};
   assign div_ge    = div_trial >= {1'b0, den_ff};

   assign rt_trial = {rrem_ff, y_ff[Y_W-1 -: 2]};
   assign rt_test  = {1'b0, root_ff, 2'b01};
   assign rt_diff  = rt_trial - rt_test;
   assign rt_ge    = rt_trial >= rt_test;

   assign step_last = (step_ff == '0);
   assign over      = quo_ff >= DIV_W'(SCALE_SQ);

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE, PH_DONE: begin
            if (start) phase_in = PH_MUL;
         end
         PH_MUL: begin
            if (step_last) phase_in = PH_DIV;
         end
         PH_DIV: begin
            if (step_last) phase_in = PH_CLAMP;
         end
         PH_CLAMP: begin
            phase_in = over ? PH_DONE : PH_ROOT;
         end
         PH_ROOT: begin
            if (step_last) phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      sum_in  = sum_ff;
      coef_in = coef_ff;
      acc_in  = acc_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      y_in    = y_ff;
      root_in = root_ff;
      rrem_in = rrem_ff;
      unique case (phase_ff)
         PH_IDLE, PH_DONE: begin
            if (start) begin
               step_in = STEP_W'(SCALE_SQ_W - 1);
               sum_in  = sumsq;
               coef_in = SCALE_SQ;
               acc_in  = '0;
               den_in  = frames;
            end
         end
         PH_MUL: begin
            acc_in  = {acc_ff[PROD_W-2:0], 1'b0}
                      + (coef_ff[SCALE_SQ_W-1] ? PROD_W'(sum_ff) : '0);
            coef_in = {coef_ff[SCALE_SQ_W-2:0], 1'b0};
            step_in = step_ff - STEP_W'(1);
            if (step_last) begin
               step_in = STEP_W'(DIV_W - 1);
               rem_in  = '0;
               quo_in  = '0;
            end
         end
         PH_DIV: begin
            acc_in  = {acc_ff[PROD_W-2:0], 1'b0};
            rem_in  = div_ge ? div_diff[COUNT_BITS-1:0] : div_trial[COUNT_BITS-1:0];
            quo_in  = {quo_ff[DIV_W-2:0], div_ge};
            step_in = step_ff - STEP_W'(1);
         end
         PH_CLAMP: begin
            if (over) begin
               root_in = RMS_MAX;
            end else begin
               y_in    = quo_ff[Y_W-1:0];
               root_in = '0;
               rrem_in = '0;
               step_in = STEP_W'(RMS_W - 1);
            end
         end
         PH_ROOT: begin
            rrem_in = rt_ge ? rt_diff[RMS_W:0] : rt_trial[RMS_W:0];
            root_in = {root_ff[RMS_W-2:0], rt_ge};
            y_in    = {y_ff[Y_W-3:0], 2'b00};
            step_in = step_ff - STEP_W'(1);
         end
         default: begin
            step_in = '0;
         end
      endcase
   end

   assign done = (phase_ff == PH_DONE);
   assign rms  = root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         step_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      coef_ff <= coef_in;
      acc_ff  <= acc_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      y_ff    <= y_in;
      root_ff <= root_in;
      rrem_ff <= rrem_in;
   end

endmodule

FILE: rtl/audio_peak_rms_decimator.sv
// Top level: channel tracking, block framing, result sequencing and output register.
//
//  port group  dir  word                              handshake
//  req_*       in   sample_value                      req_tvalid / req_tready
//  rsp_*       out  channel, peak_max, peak_min, rms  rsp_tvalid / rsp_tready, rsp_tlast
//  csr_*       in   register index, value             csr_valid / csr_ready (always ready)
//
// A sample is accepted, then a read-modify-write updates its channel entry.
// At block end each channel's result is worked out by the bit-serial multiply, divide
// and square root in aprd_rms; no samples are taken until the last channel's result
// is in the output register.
// Reset is synchronous; it clears control state and the entry valid bits at once.
// rsp_tready low holds the output register and stalls the next channel's result.
module audio_peak_rms_decimator #(
   parameter int MAX_CHANNELS = aprd_pkg::DEF_MAX_CHANNELS,
   parameter int SAMPLE_BITS  = aprd_pkg::DEF_SAMPLE_BITS,
   parameter int COUNT_BITS   = aprd_pkg::DEF_COUNT_BITS,
   localparam int REQ_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [REQ_DATA_W-1:0]           req_tdata,   // sample_value
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [aprd_pkg::RSP_DATA_W-1:0] rsp_tdata,   // channel, peak_max, peak_min, rms_level
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  aprd_pkg::csr_index_type         csr_index,
   input  logic [aprd_pkg::CSR_DATA_W-1:0] csr_data
);
   import aprd_pkg::*;

   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
   localparam int SUM_W  = 2 * SAMPLE_BITS + COUNT_BITS - 2;
   localparam int CMP_W  = (COUNT_BITS > FPB_W) ? COUNT_BITS : FPB_W;
   localparam int PK_W   = SAMPLE_BITS + 11;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   function automatic logic signed [PEAK_W-1:0] scale_peak(
      input logic signed [SAMPLE_BITS-1:0] v);
      logic signed [PK_W-1:0] prod;
      logic signed [PK_W-1:0] biased;
      prod   = PK_W'(v) * signed'(PK_W'(PEAK_SCALE));
      biased = prod[PK_W-1] ? prod + signed'(PK_W'((1 << (SAMPLE_BITS - 1)) - 1)) : prod;
      return PEAK_W'(biased >>> (SAMPLE_BITS - 1));
   endfunction

   aprd_state_type state_ff, state_in;

   logic [FPB_W-1:0]           fpb_ff;
   logic [CHANNEL_COUNT_W-1:0] cc_ff;
   logic [CH_W-1:0]            pos_ff, pos_in;
   logic [COUNT_BITS-1:0]      fc_ff, fc_in;
   logic [CH_W-1:0]            emit_ch_ff, emit_ch_in;
   logic [NCH_W-1:0]           emit_n_ff, emit_n_in;
   logic signed [PEAK_W-1:0]   pmax_ff, pmin_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [NCH_W-1:0]      n_eff;
   logic                  eof;
   logic [COUNT_BITS-1:0] fc_inc;
   logic                  emit_now;
   logic                  last_ch;
   logic                  out_free;
   logic                  out_load;
   logic                  rms_start;
   logic                  rms_done;
   logic [RMS_W-1:0]      rms_val;
   logic [CH_W-1:0]       sel;
   stats_ctrl_type        stats_ctrl;

   logic signed [SAMPLE_BITS-1:0] rd_max;
   logic signed [SAMPLE_BITS-1:0] rd_min;
   logic [SUM_W-1:0]              rd_sumsq;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fpb_ff <= FPB_RESET;
         cc_ff  <= CHANNEL_COUNT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAMES_PER_BLOCK: fpb_ff <= csr_data[FPB_W-1:0];
            CSR_CHANNEL_COUNT:    cc_ff  <= csr_data[CHANNEL_COUNT_W-1:0];
         endcase
      end
   end

   always_comb begin
      if (cc_ff == '0) begin
         n_eff = NCH_W'(1);
      end else if (int'(cc_ff) > MAX_CHANNELS) begin
         n_eff = NCH_W'(MAX_CHANNELS);
      end else begin
         n_eff = NCH_W'(cc_ff);
      end
   end

   assign eof      = (int'(pos_ff) + 1) >= int'(n_eff);
   assign fc_inc   = (fc_ff == COUNT_MAX) ? fc_ff : fc_ff + COUNT_BITS'(1);
   assign emit_now = eof && ((CMP_W'(fc_inc) >= CMP_W'(fpb_ff)) || (fc_inc == COUNT_MAX));
   assign last_ch  = (int'(emit_ch_ff) + 1) == int'(emit_n_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = emit_now ? ST_EMIT_START : ST_IDLE;
         end
         ST_EMIT_START: begin
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (rms_done) state_in = ST_EMIT_PUT;
         end
         ST_EMIT_PUT: begin
            if (out_free) state_in = last_ch ? ST_IDLE : ST_EMIT_START;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_tready        = 1'b0;
      stats_ctrl.load   = 1'b0;
      stats_ctrl.update = 1'b0;
      stats_ctrl.clear  = 1'b0;
      sel               = emit_ch_ff;
      rms_start         = 1'b0;
      out_load          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready      = 1'b1;
            stats_ctrl.load = req_tvalid;
         end
         ST_UPDATE: begin
            stats_ctrl.update = 1'b1;
            sel               = pos_ff;
         end
         ST_EMIT_START: begin
            rms_start = 1'b1;
         end
         ST_EMIT_WAIT: begin
         end
         ST_EMIT_PUT: begin
            out_load         = out_free;
            stats_ctrl.clear = out_free && last_ch;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      pos_in     = pos_ff;
      fc_in      = fc_ff;
      emit_ch_in = emit_ch_ff;
      emit_n_in  = emit_n_ff;
      if (stats_ctrl.update) begin
         pos_in = eof ? '0 : pos_ff + CH_W'(1);
         if (eof) fc_in = fc_inc;
         if (emit_now) begin
            emit_ch_in = '0;
            emit_n_in  = n_eff;
         end
      end
      if (out_load) begin
         if (last_ch) begin
            fc_in = '0;
         end else begin
            emit_ch_in = emit_ch_ff + CH_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({rms_val, pmin_ff, pmax_ff, CHAN_W'(emit_ch_ff)});
         rsp_last_in  = last_ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         fc_ff        <= '0;
         emit_ch_ff   <= '0;
         emit_n_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         fc_ff        <= fc_in;
         emit_ch_ff   <= emit_ch_in;
         emit_n_ff    <= emit_n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rms_start) begin
         pmax_ff <= scale_peak(rd_max);
         pmin_ff <= scale_peak(rd_min);
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   aprd_stats #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_stats (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (stats_ctrl),
      .sel      (sel),
      .sample   (signed'(req_tdata[SAMPLE_BITS-1:0])),
      .rd_max   (rd_max),
      .rd_min   (rd_min),
      .rd_sumsq (rd_sumsq)
   );

   aprd_rms #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_rms (
      .clock  (clock),
      .reset  (reset),
      .start  (rms_start),
      .sumsq  (rd_sumsq),
      .frames (fc_ff),
      .done   (rms_done),
      .rms    (rms_val)
   );

   a_accept_then_update: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_UPDATE)
      else $error("accepted sample not followed by entry update");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      int'(pos_ff) < MAX_CHANNELS)
      else $error("channel position out of range");

   a_rms_limit: assert property (@(posedge clock) disable iff (reset)
      rms_done |-> rms_val <= RMS_MAX)
      else $error("rms result above limit");

   a_block_restart: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT_PUT && out_free && last_ch |=> fc_ff == '0 && state_ff == ST_IDLE)
      else $error("frame count not cleared after last result");

endmodule
